FILE: hdl/b64rle_pkg.sv
`default_nettype none

package b64rle_pkg;

    // Result status codes
    localparam logic [2:0] ST_PIXEL   = 3'd0;
    localparam logic [2:0] ST_DONE    = 3'd1;
    localparam logic [2:0] ST_BADCHAR = 3'd2;
    localparam logic [2:0] ST_BADRUN  = 3'd3;
    localparam logic [2:0] ST_SHORT   = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_COLOR_COUNT  = 2'd2;

    localparam logic [7:0] CHAR_PAD = 8'h3D;   // '='
    localparam logic [3:0] NIB_MASK = 4'hF;

    localparam int TOTAL_W = 13;

    // Settled frame configuration handed to the decode engine.
    typedef struct packed {
        logic               dims_ok;
        logic [TOTAL_W-1:0] total;
        logic [3:0]         color_count;
    } frame_cfg_t;

    // Base64 symbol value 0..63; bit 6 set flags a code outside the alphabet.
    function automatic logic [6:0] b64_symbol(input logic [7:0] c);
        logic [6:0] v;
        begin
            if (c >= 8'h41 && c <= 8'h5A) begin
                v = 7'(c - 8'h41);
            end else if (c >= 8'h61 && c <= 8'h7A) begin
                v = 7'(c - 8'h61 + 8'd26);
            end else if (c >= 8'h30 && c <= 8'h39) begin
                v = 7'(c - 8'h30 + 8'd52);
            end else if (c == 8'h2B) begin
                v = 7'd62;
            end else if (c == 8'h2F) begin
                v = 7'd63;
            end else begin
                v = 7'd64;
            end
            return v;
        end
    endfunction

endpackage

`default_nettype wire

FILE: hdl/b64rle_engine.sv
`default_nettype none

module b64rle_engine (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire b64rle_pkg::frame_cfg_t cfg,
    input  wire                     in_valid,
    output logic                    in_ready,
    input  wire [7:0]               in_char,
    input  wire                     in_final,
    output logic                    out_valid,
    input  wire                     out_ready,
    output logic [3:0]              out_pixel,
    output logic [2:0]              out_status,
    output logic                    out_last
);
    import b64rle_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EVAL = 3'b010,
        S_EMIT = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [7:0]         char_reg;
    logic               fin_reg;

    logic [11:0]        acc_reg, acc_next;
    logic [3:0]         bits_reg, bits_next;
    logic [TOTAL_W-1:0] pdone_reg, pdone_next;
    logic               pad_reg, pad_next;
    logic               err_reg, err_next;

    logic               errq_reg, errq_next;
    logic [2:0]         errst_reg, errst_next;
    logic [4:0]         run_reg, run_next;
    logic [3:0]         idx_reg, idx_next;
    logic               finq_reg, finq_next;
    logic [2:0]         finst_reg, finst_next;

    logic               ov_reg, ov_next;
    logic [3:0]         opix_reg, opix_next;
    logic [2:0]         ost_reg, ost_next;
    logic               olast_reg, olast_next;

    // Evaluation temporaries
    logic [6:0]         sym;
    logic [3:0]         bits_sum;
    logic [11:0]        acc_new;
    logic [7:0]         byte_val;
    logic [4:0]         run_len;
    logic [TOTAL_W:0]   pd_sum;
    logic               have_item;
    logic               slot_free;

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = ov_reg;
    assign out_pixel  = opix_reg;
    assign out_status = ost_reg;
    assign out_last   = olast_reg;

    assign sym       = b64_symbol(char_reg);
    assign bits_sum  = bits_reg + 4'd6;
    assign acc_new   = {acc_reg[5:0], sym[5:0]};
    assign byte_val  = 8'(acc_new >> (bits_sum - 4'd8));
    assign run_len   = {1'b0, byte_val[7:4]} + 5'd1;
    assign pd_sum    = {1'b0, pdone_reg} + {{(TOTAL_W-4){1'b0}}, run_len};
    assign have_item = errq_reg || (run_reg != 5'd0) || finq_reg;
    assign slot_free = !ov_reg || out_ready;

    always_comb begin
        state_next = state_reg;
        acc_next   = acc_reg;
        bits_next  = bits_reg;
        pdone_next = pdone_reg;
        pad_next   = pad_reg;
        err_next   = err_reg;
        errq_next  = errq_reg;
        errst_next = errst_reg;
        run_next   = run_reg;
        idx_next   = idx_reg;
        finq_next  = finq_reg;
        finst_next = finst_reg;
        ov_next    = ov_reg;
        opix_next  = opix_reg;
        ost_next   = ost_reg;
        olast_next = olast_reg;

        if (ov_reg && out_ready) begin
            ov_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    state_next = S_EVAL;
                end
            end

            S_EVAL: begin
                errq_next  = 1'b0;
                run_next   = 5'd0;
                finq_next  = 1'b0;
                state_next = S_EMIT;
                if (!err_reg && !pad_reg) begin
                    if (!cfg.dims_ok) begin
                        errq_next  = 1'b1;
                        errst_next = ST_BADRUN;
                        err_next   = 1'b1;
                    end else if (char_reg == CHAR_PAD) begin
                        pad_next = 1'b1;
                    end else if (sym[6]) begin
                        errq_next  = 1'b1;
                        errst_next = ST_BADCHAR;
                        err_next   = 1'b1;
                    end else begin
                        acc_next = acc_new;
                        if (bits_sum >= 4'd8) begin
                            bits_next = bits_sum - 4'd8;
                            if ((byte_val[3:0] & NIB_MASK) > cfg.color_count ||
                                pd_sum > {1'b0, cfg.total}) begin
                                errq_next  = 1'b1;
                                errst_next = ST_BADRUN;
                                err_next   = 1'b1;
                            end else begin
                                run_next   = run_len;
                                idx_next   = byte_val[3:0];
                                pdone_next = pd_sum[TOTAL_W-1:0];
                            end
                        end else begin
                            bits_next = bits_sum;
                        end
                    end
                end
                if (fin_reg) begin
                    if (!err_next) begin
                        finq_next  = 1'b1;
                        finst_next = (pdone_next == cfg.total) ? ST_DONE : ST_SHORT;
                    end
                    acc_next   = '0;
                    bits_next  = '0;
                    pdone_next = '0;
                    pad_next   = 1'b0;
                    err_next   = 1'b0;
                end
            end

            S_EMIT: begin
                // The run counter is the shared unit: one result per free slot.
                if (!have_item) begin
                    state_next = S_IDLE;
                end else if (slot_free) begin
                    ov_next = 1'b1;
                    if (errq_reg) begin
                        opix_next  = 4'd0;
                        ost_next   = errst_reg;
                        olast_next = 1'b1;
                        errq_next  = 1'b0;
                    end else if (run_reg != 5'd0) begin
                        opix_next  = idx_reg;
                        ost_next   = ST_PIXEL;
                        olast_next = (run_reg == 5'd1) && !finq_reg;
                        run_next   = run_reg - 5'd1;
                    end else begin
                        opix_next  = 4'd0;
                        ost_next   = finst_reg;
                        olast_next = 1'b1;
                        finq_next  = 1'b0;
                    end
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            acc_reg   <= '0;
            bits_reg  <= '0;
            pdone_reg <= '0;
            pad_reg   <= 1'b0;
            err_reg   <= 1'b0;
            errq_reg  <= 1'b0;
            run_reg   <= '0;
            finq_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
            bits_reg  <= bits_next;
            pdone_reg <= pdone_next;
            pad_reg   <= pad_next;
            err_reg   <= err_next;
            errq_reg  <= errq_next;
            run_reg   <= run_next;
            finq_reg  <= finq_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && in_valid) begin
            char_reg <= in_char;
            fin_reg  <= in_final;
        end
        errst_reg <= errst_next;
        idx_reg   <= idx_next;
        finst_reg <= finst_next;
        opix_reg  <= opix_next;
        ost_reg   <= ost_next;
        olast_reg <= olast_next;
    end

endmodule

`default_nettype wire

FILE: hdl/base64_rle_sprite_decoder.sv
// Base64 run-length sprite decoder.
// The s_ channel carries one base64 character per transaction in s_tdata,
// with s_tlast marking the last character of the frame text. Each decoded
// byte is a run: high nibble plus one pixels of the palette index in the low
// nibble. The m_ channel carries one result per transaction: the pixel index
// in m_tdata, the status in m_tuser (pixel, frame complete, bad character,
// bad run, short frame) and m_tlast on the last result of each character.
// The cfg_ channel writes frame width, frame height and color count; write
// it only while the decoder is idle.
// A character passes through an accept step in idle, an evaluation step and
// the emit step, which loads the results it causes (0 to 17) one at a time
// through the run counter, before the decoder returns to idle. The first result
// is registered by the evaluation state and then loaded into the output register.
// A stalled receiver holds the output register; the run counter waits and
// s_tready stays low until every result of the character has been loaded.
// Reset (aresetn low at a clock edge) clears the frame state and restores
// width 1, height 1 and color count 0.
`default_nettype none

module base64_rle_sprite_decoder #(
    parameter int MAX_WIDTH  = 80,
    parameter int MAX_HEIGHT = 60
) (
    input  wire        aclk,
    input  wire        aresetn,
    // Input channel
    input  wire        s_tvalid,
    output logic       s_tready,
    input  wire  [7:0] s_tdata,    // [7:0] char_code
    input  wire        s_tlast,    // final_char
    // Result channel
    output logic       m_tvalid,
    input  wire        m_tready,
    output logic [7:0] m_tdata,    // [3:0] pixel_index, [7:4] zero
    output logic [2:0] m_tuser,    // [2:0] status
    output logic       m_tlast,    // last result of the character
    // Configuration write channel
    input  wire        cfg_valid,
    output logic       cfg_ready,
    input  wire  [1:0] cfg_index,
    input  wire  [6:0] cfg_wdata
);
    import b64rle_pkg::*;

    logic [6:0] width_reg;
    logic [5:0] height_reg;
    logic [3:0] colors_reg;

    // Derived frame parameters are registered, so they settle before the next character; the
    // user must change configuration only while idle, which the block does not enforce.
    logic               dims_ok_reg, dims_ok_next;
    logic [TOTAL_W-1:0] total_reg, total_next;

    frame_cfg_t cfg;
    logic [3:0] pixel;

    assign cfg_ready = 1'b1;

    assign dims_ok_next = (width_reg != 7'd0) && (int'(width_reg) <= MAX_WIDTH) &&
                          (height_reg != 6'd0) && (int'(height_reg) <= MAX_HEIGHT);
    assign total_next   = {6'd0, width_reg} * {7'd0, height_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 7'd1;
            height_reg <= 6'd1;
            colors_reg <= 4'd0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_FRAME_WIDTH:  width_reg  <= cfg_wdata;
                REG_FRAME_HEIGHT: height_reg <= cfg_wdata[5:0];
                REG_COLOR_COUNT:  colors_reg <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        dims_ok_reg <= dims_ok_next;
        total_reg   <= total_next;
    end

    assign cfg.dims_ok     = dims_ok_reg;
    assign cfg.total       = total_reg;
    assign cfg.color_count = colors_reg;

    b64rle_engine u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_char    (s_tdata),
        .in_final   (s_tlast),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_pixel  (pixel),
        .out_status (m_tuser),
        .out_last   (m_tlast)
    );

    assign m_tdata = {4'd0, pixel};

endmodule

`default_nettype wire

FILE: hdl/b64rle_checker.sv
`default_nettype none

module b64rle_checker (
    input wire       aclk,
    input wire       aresetn,
    input wire       s_tready,
    input wire       m_tvalid,
    input wire       m_tready,
    input wire [7:0] m_tdata,
    input wire [2:0] m_tuser,
    input wire       m_tlast
);
    import b64rle_pkg::*;

    // A stalled result holds its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
        $stable(m_tuser) && $stable(m_tlast))
        else $error("result changed while stalled");

    // Status and error results carry no pixel and always end the character.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ST_PIXEL |-> m_tdata == 8'd0 && m_tlast)
        else $error("non-pixel result malformed");

    // Only the five defined status codes appear.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser == ST_PIXEL || m_tuser == ST_DONE ||
        m_tuser == ST_BADCHAR || m_tuser == ST_BADRUN || m_tuser == ST_SHORT)
        else $error("undefined status code");

    // No new character is taken while a run is still being emitted.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input accepted in the middle of a run");

endmodule

bind base64_rle_sprite_decoder b64rle_checker u_b64rle_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
